@@ src/vce_pkg.sv @@
package vce_pkg;

    localparam int INDEX_W    = 4;
    localparam int ENTRIES_W  = 5;
    localparam int VALUE_W    = 32;
    localparam int ACTION_W   = 3;
    localparam int S_TDATA_W  = 40;
    localparam int M_TDATA_W  = 40;
    localparam int CFG_DATA_W = 5;

    localparam logic [INDEX_W-1:0]   OWN_INDEX_RESET = 4'd0;
    localparam logic [ENTRIES_W-1:0] ENTRIES_RESET   = 5'd16;

    // configuration register indexes
    localparam logic REG_OWN_INDEX      = 1'b0;
    localparam logic REG_ENTRIES_IN_USE = 1'b1;

    // result kinds
    localparam logic KIND_ORDER = 1'b0;
    localparam logic KIND_READ  = 1'b1;

    typedef enum logic [ACTION_W-1:0] {
        ACT_TICK    = 3'd0,
        ACT_MERGE   = 3'd1,
        ACT_COMPARE = 3'd2,
        ACT_READ    = 3'd3,
        ACT_LOAD    = 3'd4
    } action_t;

    typedef enum logic [1:0] {
        ORD_EQUAL      = 2'd0,
        ORD_BEFORE     = 2'd1,
        ORD_AFTER      = 2'd2,
        ORD_CONCURRENT = 2'd3
    } order_t;

    typedef struct packed {
        logic    go;
        action_t action;
        logic    in_use;
        logic    last;
    } exec_ctl_t;

    typedef struct packed {
        logic               has_result;
        logic               kind;
        order_t             order;
        logic [VALUE_W-1:0] value;
    } result_t;

endpackage

@@ src/vce_counter_ram.sv @@
module vce_counter_ram
    import vce_pkg::*;
#(
    parameter int DEPTH = 16,
    parameter int WIDTH = 32,
    parameter int AW    = 4
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;
    logic [AW-1:0]    rd_addr_reg;
    logic             fwd_hit_reg;
    logic [WIDTH-1:0] fwd_data_reg;
    logic [DEPTH-1:0] valid_reg;

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // a write landing on the entry being read in the same cycle is forwarded
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_addr_reg  <= rd_addr;
            fwd_hit_reg  <= wr_en && (wr_addr == rd_addr);
            fwd_data_reg <= wr_data;
        end
    end

    // entries never written since reset read as zero
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else if (wr_en) begin
            valid_reg[wr_addr] <= 1'b1;
        end
    end

    assign rd_data = fwd_hit_reg          ? fwd_data_reg :
                     valid_reg[rd_addr_reg] ? rd_data_reg  : '0;

    a_wr_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        wr_en |-> (32'(wr_addr) < DEPTH))
        else $error("counter write outside the vector");

endmodule

@@ src/vce_exec.sv @@
module vce_exec
    import vce_pkg::*;
#(
    parameter int CB = 32
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  exec_ctl_t     ctl,
    input  logic [CB-1:0] value,
    input  logic [CB-1:0] current,
    output logic          wr_en,
    output logic [CB-1:0] wr_data,
    output result_t       res
);

    logic             local_seen_reg, local_seen_next;
    logic             other_seen_reg, other_seen_next;
    logic             wr_req;
    logic             local_gt, other_gt;
    logic [CB+31:0]   current_wide;

    assign local_gt     = current > value;
    assign other_gt     = value > current;
    assign current_wide = {32'd0, current};

    always_comb begin
        local_seen_next = local_seen_reg;
        other_seen_next = other_seen_reg;
        wr_req          = 1'b0;
        wr_data         = current;
        res             = '0;
        res.kind        = KIND_ORDER;
        res.order       = ORD_EQUAL;
        unique case (ctl.action)
            ACT_TICK: begin
                // saturate at all ones
                if (ctl.in_use && !(&current)) begin
                    wr_req  = 1'b1;
                    wr_data = current + CB'(1);
                end
            end
            ACT_MERGE: begin
                if (ctl.in_use && other_gt) begin
                    wr_req  = 1'b1;
                    wr_data = value;
                end
            end
            ACT_COMPARE: begin
                if (ctl.in_use) begin
                    local_seen_next = local_seen_reg | local_gt;
                    other_seen_next = other_seen_reg | other_gt;
                end
                if (ctl.last) begin
                    res.has_result = 1'b1;
                    if (!local_seen_next && !other_seen_next) begin
                        res.order = ORD_EQUAL;
                    end else if (!local_seen_next) begin
                        res.order = ORD_BEFORE;
                    end else if (!other_seen_next) begin
                        res.order = ORD_AFTER;
                    end else begin
                        res.order = ORD_CONCURRENT;
                    end
                    local_seen_next = 1'b0;
                    other_seen_next = 1'b0;
                end
            end
            ACT_READ: begin
                res.has_result = 1'b1;
                res.kind       = KIND_READ;
                res.value      = ctl.in_use ? current_wide[31:0] : 32'd0;
            end
            ACT_LOAD: begin
                if (ctl.in_use) begin
                    wr_req  = 1'b1;
                    wr_data = value;
                end
            end
            default: ;
        endcase
    end

    assign wr_en = ctl.go && wr_req;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            local_seen_reg <= 1'b0;
            other_seen_reg <= 1'b0;
        end else if (ctl.go) begin
            local_seen_reg <= local_seen_next;
            other_seen_reg <= other_seen_next;
        end
    end

    a_flags_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        ctl.go && (ctl.action == ACT_COMPARE) && ctl.last
        |=> !local_seen_reg && !other_seen_reg)
        else $error("order flags not cleared after last compare");

    a_wr_in_use: assert property (@(posedge aclk) disable iff (!aresetn)
        wr_en |-> ctl.in_use)
        else $error("write to an entry out of use");

endmodule

@@ src/vector_clock_engine.sv @@
// Vector clock engine: one local vector of per-process counters in a small
// synchronous RAM.
// Input stream (s_*): s_tuser carries the action (tick, merge, compare,
// read, load), s_tdata the entry index and value, s_tlast marks the final
// compare element of a run. Output stream (m_*): m_tuser is the result kind
// (order result or read data), m_tdata the order code and counter value.
// Only reads and last compare elements produce an output transaction.
// Configuration: cfg_wr_en writes cfg_wdata into register cfg_index
// (0 own index, 1 entries in use); write only while the engine is idle.
// Flow: an accepted item and its RAM read are registered into the update
// stage; its result then goes to the output register that drives m_tvalid.
// Throughput: one transaction per cycle when not stalled (see below); each
// item does one read and at most one write of the counter RAM, with
// same-entry writes forwarded. When the receiver stalls with a result held,
// items without a result keep flowing; the next result-producing item waits
// in the update stage and holds s_tready low until the held result is taken.
// Reset clears all counters (per-entry valid bits), the order flags, the
// output register and restores the configuration defaults.
module vector_clock_engine
    import vce_pkg::*;
#(
    parameter int MAX_PROCESSES = 16,
    parameter int COUNTER_BITS  = 32
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [S_TDATA_W-1:0]  s_tdata,   // entry_index[3:0], incoming_value[35:4], zero
    input  logic [ACTION_W-1:0]   s_tuser,   // action[2:0]
    input  logic                  s_tlast,   // last_element
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [M_TDATA_W-1:0]  m_tdata,   // order[1:0], counter_value[33:2], zero
    output logic                  m_tuser,   // result_kind
    input  logic                  cfg_wr_en,
    input  logic                  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata
);

    localparam int AW    = $clog2(MAX_PROCESSES);
    localparam int CMP_W = ((AW > INDEX_W) ? AW : INDEX_W) + 1;

    logic [INDEX_W-1:0]   own_index_reg;
    logic [ENTRIES_W-1:0] entries_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            own_index_reg <= OWN_INDEX_RESET;
            entries_reg   <= ENTRIES_RESET;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                REG_OWN_INDEX:      own_index_reg <= cfg_wdata[INDEX_W-1:0];
                REG_ENTRIES_IN_USE: entries_reg   <= cfg_wdata[ENTRIES_W-1:0];
                default: ;
            endcase
        end
    end

    // stage 0: decode, in-use check, RAM read
    action_t                 s0_action;
    logic [INDEX_W-1:0]      s0_index;
    logic [CMP_W-1:0]        s0_index_wide;
    logic                    s0_in_use;
    logic [COUNTER_BITS+31:0] s0_value_wide;
    logic                    accept;

    assign s0_action     = action_t'(s_tuser);
    assign s0_index      = (s0_action == ACT_TICK) ? own_index_reg : s_tdata[INDEX_W-1:0];
    assign s0_index_wide = CMP_W'(s0_index);
    assign s0_in_use     = ({1'b0, s0_index} < entries_reg)
                        && (s0_index_wide < CMP_W'(MAX_PROCESSES));
    assign s0_value_wide = {{COUNTER_BITS{1'b0}}, s_tdata[VALUE_W+INDEX_W-1:INDEX_W]};

    // stage 1: update and result
    logic                    s1_valid_reg;
    action_t                 s1_action_reg;
    logic                    s1_in_use_reg;
    logic                    s1_last_reg;
    logic [COUNTER_BITS-1:0] s1_value_reg;
    logic [AW-1:0]           s1_addr_reg;
    logic                    s1_go;
    logic                    out_free;

    logic                    m_tvalid_reg;
    logic                    m_kind_reg;
    order_t                  m_order_reg;
    logic [VALUE_W-1:0]      m_value_reg;

    exec_ctl_t               ctl;
    result_t                 res;
    logic                    wr_en;
    logic [COUNTER_BITS-1:0] wr_data;
    logic [COUNTER_BITS-1:0] current;

    assign out_free = !m_tvalid_reg || m_tready;
    assign s1_go    = s1_valid_reg && (!res.has_result || out_free);
    assign s_tready = !s1_valid_reg || s1_go;
    assign accept   = s_tvalid && s_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
        end else if (accept) begin
            s1_valid_reg <= 1'b1;
        end else if (s1_go) begin
            s1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            s1_action_reg <= s0_action;
            s1_in_use_reg <= s0_in_use;
            s1_last_reg   <= s_tlast;
            s1_value_reg  <= s0_value_wide[COUNTER_BITS-1:0];
            s1_addr_reg   <= s0_index_wide[AW-1:0];
        end
    end

    vce_counter_ram #(
        .DEPTH (MAX_PROCESSES),
        .WIDTH (COUNTER_BITS),
        .AW    (AW)
    ) u_ram (
        .aclk    (aclk),
        .aresetn (aresetn),
        .rd_en   (accept),
        .rd_addr (s0_index_wide[AW-1:0]),
        .wr_en   (wr_en),
        .wr_addr (s1_addr_reg),
        .wr_data (wr_data),
        .rd_data (current)
    );

    assign ctl.go     = s1_go;
    assign ctl.action = s1_action_reg;
    assign ctl.in_use = s1_in_use_reg;
    assign ctl.last   = s1_last_reg;

    vce_exec #(
        .CB (COUNTER_BITS)
    ) u_exec (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctl     (ctl),
        .value   (s1_value_reg),
        .current (current),
        .wr_en   (wr_en),
        .wr_data (wr_data),
        .res     (res)
    );

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (s1_go && res.has_result) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s1_go && res.has_result) begin
            m_kind_reg  <= res.kind;
            m_order_reg <= res.order;
            m_value_reg <= res.value;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tuser  = m_kind_reg;
    assign m_tdata  = {6'd0, m_value_reg, m_order_reg};

    a_order_no_value: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tuser == KIND_ORDER) |-> (m_tdata[33:2] == 32'd0))
        else $error("order result carries a counter value");

    a_read_no_order: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tuser == KIND_READ) |-> (m_tdata[1:0] == ORD_EQUAL))
        else $error("read data carries an order code");

    a_stall_holds_item: assert property (@(posedge aclk) disable iff (!aresetn)
        s1_valid_reg && !s1_go |=> s1_valid_reg && $stable(s1_addr_reg))
        else $error("stalled item lost from the update stage");

endmodule
